// ----- rtl/dfiir_pkg.sv -----
// Shared widths, constants and types of the direct form I IIR filter.
package dfiir_pkg;

	localparam int MAX_TAPS_DEF = 64;

	localparam int CODE_W  = 14;
	localparam int COEF_W  = 24;
	localparam int YH_W    = 32;
	localparam int ORDER_W = 7;
	localparam int ACC_W   = 64;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [0:0] REG_FILTER_ORDER = 1'b0;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd1;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// ----- rtl/dfiir_mac.sv -----
// Multiply-accumulate, rounding and output saturation of the IIR filter.
module dfiir_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dfiir_pkg::mac_ctl_t                     ctl,
	input  logic signed [dfiir_pkg::COEF_W-1:0]     b_coef,
	input  logic signed [dfiir_pkg::COEF_W-1:0]     a_coef,
	input  logic signed [dfiir_pkg::CODE_W-1:0]     x_val,
	input  logic signed [dfiir_pkg::YH_W-1:0]       y_val,
	output logic                                    done,
	output logic signed [dfiir_pkg::YH_W-1:0]       y_out,
	output logic [dfiir_pkg::CODE_W-1:0]            dac_code,
	output logic                                    clipped
);

	localparam int COEF_W     = dfiir_pkg::COEF_W;
	localparam int CODE_W     = dfiir_pkg::CODE_W;
	localparam int YH_W       = dfiir_pkg::YH_W;
	localparam int ACC_W      = dfiir_pkg::ACC_W;
	localparam int PB_W       = COEF_W + CODE_W;
	localparam int PA_W       = COEF_W + YH_W;
	localparam int Y_FRAC     = 8;
	localparam int COEF_FRAC  = 20;
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [YH_W-1:0] Y_HI =
		YH_W'(((1 << (CODE_W - 1)) - 1) * (1 << Y_FRAC));
	localparam logic signed [YH_W-1:0] Y_LO =
		YH_W'(-(1 << (CODE_W - 1)) * (1 << Y_FRAC));
	localparam logic signed [YH_W-1:0] HALF_LSB = YH_W'(1 << (Y_FRAC - 1));
	localparam logic signed [YH_W-1:0] SAT_HI = {1'b0, {(YH_W-1){1'b1}}};
	localparam logic signed [YH_W-1:0] SAT_LO = {1'b1, {(YH_W-1){1'b0}}};

	dfiir_pkg::mac_ctl_t              ctl_s2;
	logic signed [PB_W-1:0]           pb_s2;
	logic signed [PA_W-1:0]           pa_s2;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [ACC_W-1:0]          acc_base;
	logic signed [ACC_W-1:0]          acc_nxt;
	logic                             fin_s3;
	logic                             fin_s4;
	logic                             done_q;
	logic signed [ACC_W-1:0]          rnd;
	logic signed [ACC_W-1:0]          yw;
	logic signed [YH_W-1:0]           y_sat;
	logic signed [YH_W-1:0]           y_s4;
	logic signed [YH_W-1:0]           yc;
	logic signed [YH_W-1:0]           yr;
	logic                             clip_nxt;
	logic [CODE_W-1:0]                dac_s5;
	logic                             clip_s5;

	always_ff @(posedge clk) begin
		pb_s2 <= b_coef * x_val;
		pa_s2 <= a_coef * y_val;
	end

	// The input term carries 20 fraction bits; shifting by 8 aligns it with the
	// feedback term, which already has 28.
	assign acc_base = ctl_s2.first ? ACC_W'(0) : acc_q;
	assign acc_nxt  = acc_base + (ACC_W'(pb_s2) <<< Y_FRAC) - ACC_W'(pa_s2);

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= acc_nxt;
		end
	end

	assign rnd = acc_q + RND_BIAS;
	assign yw  = rnd >>> COEF_FRAC;

	always_comb begin
		if (!yw[ACC_W-1] && (|yw[ACC_W-2:YH_W-1])) begin
			y_sat = SAT_HI;
		end else if (yw[ACC_W-1] && !(&yw[ACC_W-2:YH_W-1])) begin
			y_sat = SAT_LO;
		end else begin
			y_sat = yw[YH_W-1:0];
		end
	end

	always_comb begin
		if (y_s4 > Y_HI) begin
			yc       = Y_HI;
			clip_nxt = 1'b1;
		end else if (y_s4 < Y_LO) begin
			yc       = Y_LO;
			clip_nxt = 1'b1;
		end else begin
			yc       = y_s4;
			clip_nxt = 1'b0;
		end
	end

	assign yr = yc + HALF_LSB;

	always_ff @(posedge clk) begin
		if (fin_s3) begin
			y_s4 <= y_sat;
		end
		if (fin_s4) begin
			dac_s5  <= yr[Y_FRAC+CODE_W-1:Y_FRAC];
			clip_s5 <= clip_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			fin_s3 <= 1'b0;
			fin_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			fin_s3 <= ctl_s2.valid && ctl_s2.last;
			fin_s4 <= fin_s3;
			done_q <= fin_s4;
		end
	end

	assign done     = done_q;
	assign y_out    = y_s4;
	assign dac_code = dac_s5;
	assign clipped  = clip_s5;

endmodule

// ----- rtl/direct_form_one_iir_filter.sv -----
// Top level of the direct form I IIR filter: coefficient and history memories, sequencer.
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_stall    req_type adc_code coef_bank coef_index coef_value
//  out       out  out_valid / out_stall  dac_code clipped
//  config    in   APB psel/penable       filter_order at byte address 0
//
// A coefficient beat is written as it is taken. A sample beat walks one tap per cycle
// through the coefficient and history memories, then through the accumulator registers into
// the output register; a new beat is taken once that result sits in the output register.
// Reset clears the valid bits of every memory row at once, so no clearing pass follows.
// While out_stall holds an earlier result, a finished sample waits before its last step.
module direct_form_one_iir_filter #(
	parameter int MAX_TAPS = dfiir_pkg::MAX_TAPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic [dfiir_pkg::CODE_W-1:0]          adc_code,
	input  logic                                  coef_bank,
	input  logic [5:0]                            coef_index,
	input  logic signed [dfiir_pkg::COEF_W-1:0]   coef_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dfiir_pkg::CODE_W-1:0]          dac_code,
	output logic                                  clipped,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dfiir_pkg::PADDR_W-1:0]         paddr,
	input  logic [dfiir_pkg::PDATA_W-1:0]         pwdata,
	output logic [dfiir_pkg::PDATA_W-1:0]         prdata,
	output logic                                  pready
);

	localparam int CODE_W  = dfiir_pkg::CODE_W;
	localparam int COEF_W  = dfiir_pkg::COEF_W;
	localparam int YH_W    = dfiir_pkg::YH_W;
	localparam int ORDER_W = dfiir_pkg::ORDER_W;
	localparam int PDATA_W = dfiir_pkg::PDATA_W;
	localparam int TAP_W   = $clog2(MAX_TAPS);
	localparam int HIST_D  = MAX_TAPS - 1;
	localparam int HIST_W  = (MAX_TAPS > 2) ? $clog2(MAX_TAPS - 1) : 1;
	localparam int ROW_W   = CODE_W + YH_W;
	localparam int CROW_W  = 2 * COEF_W;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;
	localparam logic BANK_A     = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic [TAP_W-1:0]           k_q;
	logic [TAP_W-1:0]           last_q;
	logic [TAP_W-1:0]           top_q;
	logic signed [CODE_W-1:0]   x_q;
	logic                       out_valid_q;
	logic [CODE_W-1:0]          dac_code_q;
	logic                       clipped_q;
	logic [ORDER_W-1:0]         order_q;

	logic [TAP_W-1:0]           last_nxt;
	logic [TAP_W-1:0]           top_nxt;
	logic                       in_acc;
	logic                       cfg_we;
	logic                       coef_we;
	logic [TAP_W-1:0]           coef_wa;

	logic [CROW_W-1:0]          coef_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]        coef_bv_q;
	logic [MAX_TAPS-1:0]        coef_av_q;
	logic [CROW_W-1:0]          coef_rd_s1;
	logic                       coef_bv_s1;
	logic                       coef_av_s1;

	logic [ROW_W-1:0]           hist_mem [HIST_D];
	logic [HIST_D-1:0]          hist_vld_q;
	logic [ROW_W-1:0]           hist_rd_s1;
	logic                       hist_v_s1;
	logic [HIST_W-1:0]          hist_ra;
	logic                       hist_shift_we;
	logic                       fin_we;
	logic                       hist_we;
	logic [HIST_W-1:0]          hist_wa;
	logic [ROW_W-1:0]           hist_wd;

	dfiir_pkg::mac_ctl_t        rd_s1;
	logic [TAP_W-1:0]           k_s1;

	logic signed [COEF_W-1:0]   b_eff;
	logic signed [COEF_W-1:0]   a_eff;
	logic signed [CODE_W-1:0]   hx_eff;
	logic signed [YH_W-1:0]     hy_eff;
	logic signed [CODE_W-1:0]   x_op;

	logic                       mac_done;
	logic signed [YH_W-1:0]     mac_y;
	logic [CODE_W-1:0]          mac_code;
	logic                       mac_clip;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready
		&& (paddr[2] == dfiir_pkg::REG_FILTER_ORDER);
	assign prdata = (paddr[2] == dfiir_pkg::REG_FILTER_ORDER) ? PDATA_W'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= dfiir_pkg::ORDER_RESET;
		end else if (cfg_we) begin
			order_q <= pwdata[ORDER_W-1:0];
		end
	end

	// An order of zero behaves as one, and orders beyond the tap count are capped.
	always_comb begin
		if (order_q == '0) begin
			last_nxt = '0;
		end else if (32'(order_q) > MAX_TAPS) begin
			last_nxt = TAP_W'(MAX_TAPS - 1);
		end else begin
			last_nxt = TAP_W'(order_q - 1'b1);
		end
		top_nxt = (32'(last_nxt) > MAX_TAPS - 2) ? TAP_W'(MAX_TAPS - 2) : last_nxt;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign coef_we  = in_acc && (req_type == REQ_COEF) && (32'(coef_index) < MAX_TAPS);
	assign coef_wa  = coef_index[TAP_W-1:0];

	// Coefficient memory: one row holds b[k] in the low half and a[k] in the high half.
	always_ff @(posedge clk) begin
		coef_rd_s1 <= coef_mem[k_q];
		if (coef_we) begin
			if (coef_bank == BANK_A) begin
				coef_mem[coef_wa][CROW_W-1:COEF_W] <= coef_value;
			end else begin
				coef_mem[coef_wa][COEF_W-1:0] <= coef_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_bv_q  <= '0;
			coef_av_q  <= '0;
			coef_bv_s1 <= 1'b0;
			coef_av_s1 <= 1'b0;
		end else begin
			coef_bv_s1 <= coef_bv_q[k_q];
			coef_av_s1 <= coef_av_q[k_q];
			if (coef_we) begin
				if (coef_bank == BANK_A) begin
					coef_av_q[coef_wa] <= 1'b1;
				end else begin
					coef_bv_q[coef_wa] <= 1'b1;
				end
			end
		end
	end

	// History memory: row k holds x[n-1-k] and y[n-1-k]. Tap k reads row k-1 and the
	// shift writes that row into row k in the following cycle; the read of row k in that
	// same cycle returns the old contents, which the next shift step needs.
	assign hist_ra       = (k_q == '0) ? '0 : HIST_W'(k_q - 1'b1);
	assign hist_shift_we = rd_s1.valid && (k_s1 != '0) && (k_s1 <= top_q);
	assign fin_we        = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign hist_we       = hist_shift_we || fin_we;
	assign hist_wa       = fin_we ? '0 : k_s1[HIST_W-1:0];
	assign hist_wd       = fin_we ? {x_q, mac_y} : {hx_eff, hy_eff};

	always_ff @(posedge clk) begin
		hist_rd_s1 <= hist_mem[hist_ra];
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			hist_v_s1  <= 1'b0;
		end else begin
			hist_v_s1 <= hist_vld_q[hist_ra];
			if (hist_we) begin
				hist_vld_q[hist_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= '0;
			k_s1  <= '0;
		end else begin
			rd_s1.valid <= (state_q == ST_RUN);
			rd_s1.first <= (k_q == '0);
			rd_s1.last  <= (k_q == last_q);
			k_s1        <= k_q;
		end
	end

	// Rows never written read as zero. Tap zero uses the new sample and no feedback.
	assign b_eff  = coef_bv_s1 ? coef_rd_s1[COEF_W-1:0] : '0;
	assign a_eff  = (coef_av_s1 && !rd_s1.first) ? coef_rd_s1[CROW_W-1:COEF_W] : '0;
	assign hx_eff = hist_v_s1 ? hist_rd_s1[ROW_W-1:YH_W] : '0;
	assign hy_eff = hist_v_s1 ? hist_rd_s1[YH_W-1:0] : '0;
	assign x_op   = rd_s1.first ? x_q : hx_eff;

	dfiir_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rd_s1),
		.b_coef   (b_eff),
		.a_coef   (a_eff),
		.x_val    (x_op),
		.y_val    (hy_eff),
		.done     (mac_done),
		.y_out    (mac_y),
		.dac_code (mac_code),
		.clipped  (mac_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			last_q      <= '0;
			top_q       <= '0;
			x_q         <= '0;
			out_valid_q <= 1'b0;
			dac_code_q  <= '0;
			clipped_q   <= 1'b0;
		end else begin
			// The output register refills in the cycle its beat is taken.
			out_valid_q <= fin_we || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (req_type == REQ_SAMPLE)) begin
						x_q     <= $signed(adc_code);
						last_q  <= last_nxt;
						top_q   <= top_nxt;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= k_q + 1'b1;
					if (k_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_we) begin
						dac_code_q  <= mac_code;
						clipped_q   <= mac_clip;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign dac_code  = dac_code_q;
	assign clipped   = clipped_q;

	a_idle_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_s1.valid)
		else $error("tap read still in flight while idle");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("accumulator finished outside the drain phase");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result appeared without a finished sample");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= last_q))
		else $error("tap counter ran past the active order");

	a_hist_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(hist_shift_we && fin_we))
		else $error("two writes to the history memory in one cycle");

endmodule
